[design/ipv4_trie_longest_prefix_match_macros.svh]
// Assertion macros for the routing table RTL.
`ifndef IPV4_TRIE_LONGEST_PREFIX_MATCH_MACROS_SVH
`define IPV4_TRIE_LONGEST_PREFIX_MATCH_MACROS_SVH
`ifndef ASSERT_OFF
`define IPTRIE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define IPTRIE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define IPTRIE_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define IPTRIE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[design/iptrie_pkg.sv]
// Types, constants and command codes of the IPv4 trie routing table.
`default_nettype none
package iptrie_pkg;
   localparam int NODE_COUNT_DEFAULT = 4096;
   localparam int ADDRESS_BITS       = 32;
   localparam int CMD_W              = 2;
   localparam int LEN_W              = 6;
   localparam int IFACE_W            = 8;
   localparam int METRIC_W           = 16;
   localparam int ROUTES_W           = 13;
   localparam int REQ_DATA_W         = 96;
   localparam int REQ_USER_W         = 2;
   localparam int RSP_DATA_W         = 112;
   localparam int RSP_USER_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_ROUTE,
      ST_SETTLE
   } walk_state_type;

   // where the current node's links come from
   typedef enum logic [1:0] {
      SRC_ROOT,
      SRC_RAM,
      SRC_NEW
   } node_src_type;

   typedef logic [ADDRESS_BITS-1:0] addr_type;
   typedef logic [LEN_W-1:0]        len_type;
   typedef logic [ROUTES_W-1:0]     routes_type;

   typedef struct packed {
      addr_type              prefix;
      len_type               length;
      addr_type              gateway;
      logic [IFACE_W-1:0]    iface;
      logic [METRIC_W-1:0]   metric;
   } route_entry_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      addr_type              address;
      len_type               length;
      addr_type              gateway;
      logic [IFACE_W-1:0]    iface;
      logic [METRIC_W-1:0]   metric;
   } request_type;

   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic                  table_full;
      route_entry_type       entry;
      routes_type            routes;
   } result_type;
endpackage
`default_nettype wire

[design/iptrie_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iptrie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

[design/iptrie_walker.sv]
// Trie walk engine: command sequencing, node allocation and memory accesses.
`default_nettype none
module iptrie_walker #(
   parameter int NODE_COUNT = iptrie_pkg::NODE_COUNT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire iptrie_pkg::request_type            req_item,
   input  wire logic                               out_free,
   output iptrie_pkg::result_type                  result,
   output logic                                    node_we,
   output logic [$clog2(NODE_COUNT)-1:0]           node_waddr,
   output logic [2*$clog2(NODE_COUNT):0]           node_wdata,
   output logic                                    node_re,
   output logic [$clog2(NODE_COUNT)-1:0]           node_raddr,
   input  wire logic [2*$clog2(NODE_COUNT):0]      node_rdata,
   output logic                                    route_we,
   output logic [$clog2(NODE_COUNT)-1:0]           route_waddr,
   output iptrie_pkg::route_entry_type             route_wdata,
   output logic                                    route_re,
   output logic [$clog2(NODE_COUNT)-1:0]           route_raddr,
   input  wire iptrie_pkg::route_entry_type        route_rdata
);
   localparam int IW     = $clog2(NODE_COUNT);
   localparam int NODE_W = 2 * IW + 1;
   localparam logic [IW:0] POOL_SIZE = NODE_COUNT[IW:0];

   typedef logic [IW-1:0] node_idx_type;
   typedef logic [IW:0]   count_type;

   iptrie_pkg::walk_state_type  state_ff, state_in;
   logic [iptrie_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   iptrie_pkg::addr_type        path_ff, path_in;
   iptrie_pkg::len_type         lvl_ff, lvl_in;
   iptrie_pkg::len_type         target_ff, target_in;
   node_idx_type                node_ff, node_in;
   iptrie_pkg::node_src_type    src_ff, src_in;
   logic                        have_ff, have_in;
   node_idx_type                best_ff, best_in;
   iptrie_pkg::route_entry_type entry_ff, entry_in;
   count_type                   used_ff, used_in;
   count_type                   total_ff, total_in;
   node_idx_type                root_left_ff, root_left_in;
   node_idx_type                root_right_ff, root_right_in;
   logic                        root_present_ff, root_present_in;

   node_idx_type         cur_left, cur_right, child, new_idx, eff_best;
   logic                 cur_present, go_bit, child_none, at_end, pool_empty;
   logic                 is_add, is_lookup, is_clear, walk_done, eff_have;
   iptrie_pkg::len_type  len_clamped, mask_shift;
   iptrie_pkg::addr_type prefix_mask;

   always_comb begin
      case (src_ff)
         iptrie_pkg::SRC_ROOT: begin
            cur_left    = root_left_ff;
            cur_right   = root_right_ff;
            cur_present = root_present_ff;
         end
         iptrie_pkg::SRC_RAM: begin
            cur_left    = node_rdata[NODE_W-1 -: IW];
            cur_right   = node_rdata[IW:1];
            cur_present = node_rdata[0];
         end
         default: begin
            cur_left    = '0;
            cur_right   = '0;
            cur_present = 1'b0;
         end
      endcase
   end

   assign go_bit     = path_ff[iptrie_pkg::ADDRESS_BITS-1];
   assign child      = go_bit ? cur_right : cur_left;
   assign child_none = (child == '0);
   assign at_end     = (lvl_ff == target_ff);
   assign pool_empty = (used_ff >= POOL_SIZE);
   assign new_idx    = used_ff[IW-1:0];
   assign is_add     = (cmd_ff == iptrie_pkg::CMD_ADD);
   assign is_lookup  = (cmd_ff == iptrie_pkg::CMD_LOOKUP);
   assign is_clear   = (cmd_ff == iptrie_pkg::CMD_CLEAR);
   assign eff_have   = have_ff | cur_present;
   assign eff_best   = cur_present ? node_ff : best_ff;
   assign walk_done  = is_add ? (at_end || (child_none && pool_empty))
                              : (at_end || child_none);
   assign req_ready  = (state_ff == iptrie_pkg::ST_IDLE);

   assign len_clamped = (req_item.length > iptrie_pkg::len_type'(iptrie_pkg::ADDRESS_BITS))
                      ? iptrie_pkg::len_type'(iptrie_pkg::ADDRESS_BITS) : req_item.length;
   assign mask_shift  = iptrie_pkg::len_type'(iptrie_pkg::ADDRESS_BITS) - len_clamped;
   assign prefix_mask = (len_clamped == '0) ? '0
                      : ({iptrie_pkg::ADDRESS_BITS{1'b1}} << mask_shift);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iptrie_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_item.cmd == iptrie_pkg::CMD_ADD ||
                   req_item.cmd == iptrie_pkg::CMD_LOOKUP) begin
                  state_in = iptrie_pkg::ST_WALK;
               end else begin
                  state_in = iptrie_pkg::ST_SETTLE;
               end
            end
         end
         iptrie_pkg::ST_WALK: begin
            if (walk_done) begin
               if (is_lookup) begin
                  state_in = iptrie_pkg::ST_ROUTE;
               end else if (out_free) begin
                  state_in = iptrie_pkg::ST_IDLE;
               end
            end
         end
         iptrie_pkg::ST_ROUTE, iptrie_pkg::ST_SETTLE: begin
            if (out_free) begin
               state_in = iptrie_pkg::ST_IDLE;
            end
         end
         default: state_in = iptrie_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory accesses and result
   always_comb begin
      cmd_in          = cmd_ff;
      path_in         = path_ff;
      lvl_in          = lvl_ff;
      target_in       = target_ff;
      node_in         = node_ff;
      src_in          = src_ff;
      have_in         = have_ff;
      best_in         = best_ff;
      entry_in        = entry_ff;
      used_in         = used_ff;
      total_in        = total_ff;
      root_left_in    = root_left_ff;
      root_right_in   = root_right_ff;
      root_present_in = root_present_ff;
      node_we         = 1'b0;
      node_waddr      = node_ff;
      node_wdata      = {cur_left, cur_right, cur_present};
      node_re         = 1'b0;
      node_raddr      = child;
      route_we        = 1'b0;
      route_waddr     = node_ff;
      route_wdata     = entry_ff;
      route_re        = 1'b0;
      route_raddr     = eff_best;
      result          = '0;
      case (state_ff)
         iptrie_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in          = req_item.cmd;
               lvl_in          = '0;
               node_in         = '0;
               src_in          = iptrie_pkg::SRC_ROOT;
               have_in         = 1'b0;
               best_in         = '0;
               entry_in.prefix   = req_item.address & prefix_mask;
               entry_in.length   = len_clamped;
               entry_in.gateway  = req_item.gateway;
               entry_in.iface    = req_item.iface;
               entry_in.metric   = req_item.metric;
               if (req_item.cmd == iptrie_pkg::CMD_ADD) begin
                  path_in   = req_item.address & prefix_mask;
                  target_in = len_clamped;
               end else begin
                  path_in   = req_item.address;
                  target_in = iptrie_pkg::len_type'(iptrie_pkg::ADDRESS_BITS);
               end
            end
         end
         iptrie_pkg::ST_WALK: begin
            if (is_add) begin
               if (at_end) begin
                  if (out_free) begin
                     if (src_ff == iptrie_pkg::SRC_ROOT) begin
                        root_present_in = 1'b1;
                     end else begin
                        node_we    = 1'b1;
                        node_wdata = {cur_left, cur_right, 1'b1};
                     end
                     route_we     = 1'b1;
                     total_in     = total_ff + count_type'(!cur_present);
                     result.valid = 1'b1;
                  end
               end else if (!child_none) begin
                  node_re = 1'b1;
                  node_in = child;
                  src_in  = iptrie_pkg::SRC_RAM;
                  lvl_in  = lvl_ff + iptrie_pkg::len_type'(1);
                  path_in = path_ff << 1;
               end else if (pool_empty) begin
                  if (out_free) begin
                     // a node taken on this walk must still be written cleared
                     if (src_ff == iptrie_pkg::SRC_NEW) begin
                        node_we    = 1'b1;
                        node_wdata = '0;
                     end
                     result.valid      = 1'b1;
                     result.table_full = 1'b1;
                  end
               end else begin
                  if (src_ff == iptrie_pkg::SRC_ROOT) begin
                     if (go_bit) begin
                        root_right_in = new_idx;
                     end else begin
                        root_left_in = new_idx;
                     end
                  end else begin
                     node_we    = 1'b1;
                     node_wdata = go_bit ? {cur_left, new_idx, cur_present}
                                         : {new_idx, cur_right, cur_present};
                  end
                  used_in = used_ff + count_type'(1);
                  node_in = new_idx;
                  src_in  = iptrie_pkg::SRC_NEW;
                  lvl_in  = lvl_ff + iptrie_pkg::len_type'(1);
                  path_in = path_ff << 1;
               end
            end else begin
               have_in = eff_have;
               best_in = eff_best;
               if (at_end || child_none) begin
                  route_re = 1'b1;
               end else begin
                  node_re = 1'b1;
                  node_in = child;
                  src_in  = iptrie_pkg::SRC_RAM;
                  lvl_in  = lvl_ff + iptrie_pkg::len_type'(1);
                  path_in = path_ff << 1;
               end
            end
         end
         iptrie_pkg::ST_ROUTE: begin
            if (out_free) begin
               result.valid = 1'b1;
               result.found = have_ff;
               result.entry = have_ff ? route_rdata : '0;
            end
         end
         iptrie_pkg::ST_SETTLE: begin
            if (out_free) begin
               if (is_clear) begin
                  used_in         = count_type'(1);
                  total_in        = '0;
                  root_left_in    = '0;
                  root_right_in   = '0;
                  root_present_in = 1'b0;
               end
               result.valid = 1'b1;
            end
         end
         default: ;
      endcase
      result.routes = iptrie_pkg::routes_type'(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= iptrie_pkg::ST_IDLE;
         used_ff         <= count_type'(1);
         total_ff        <= '0;
         root_left_ff    <= '0;
         root_right_ff   <= '0;
         root_present_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         used_ff         <= used_in;
         total_ff        <= total_in;
         root_left_ff    <= root_left_in;
         root_right_ff   <= root_right_in;
         root_present_ff <= root_present_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      path_ff   <= path_in;
      lvl_ff    <= lvl_in;
      target_ff <= target_in;
      node_ff   <= node_in;
      src_ff    <= src_in;
      have_ff   <= have_in;
      best_ff   <= best_in;
      entry_ff  <= entry_in;
   end
endmodule
`default_nettype wire

[design/ipv4_trie_longest_prefix_match.sv]
// Top level of the IPv4 longest-prefix-match routing table.
// One request transfer carries one command (req_tuser): add a route, look up a
// destination, or clear the table. Every request yields exactly one response.
// The table is a binary trie: node links live in one RAM, route records in a
// second RAM; the root node is kept in flops so reset and clear take effect at
// once, with no sweep of either memory.
// Timing: the walker reads one trie level per cycle from the node RAM.
//   add:    walks 0..32 levels (the prefix length), then stores the route.
//   lookup: walks up to 33 levels, root included, then reads the route.
//   clear and the unused command code: settle and respond.
// The response appears in the output register at the end of that time, and
// req_tready returns high in the same cycle, so the next request may be taken
// while the response still waits. If the response register is still full when
// a new response is due, the walker holds in place until rsp_tready drains it.
// Reset empties the table (root only, no routes) and drops any pending response.
`default_nettype none
`include "ipv4_trie_longest_prefix_match_macros.svh"
module ipv4_trie_longest_prefix_match #(
   parameter int NODE_COUNT = iptrie_pkg::NODE_COUNT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // address, prefix_length, gateway, interface_index, route_metric, zero pad
   input  wire logic [iptrie_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command
   input  wire logic [iptrie_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // match_prefix, match_length, match_gateway, match_interface, match_metric,
   // routes_stored, zero pad
   output logic      [iptrie_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found, table_full
   output logic      [iptrie_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   localparam int IW     = $clog2(NODE_COUNT);
   localparam int NODE_W = 2 * IW + 1;
   localparam int PAD_W  = iptrie_pkg::RSP_DATA_W - iptrie_pkg::ROUTES_W
                         - $bits(iptrie_pkg::route_entry_type);

   iptrie_pkg::request_type     req_item;
   iptrie_pkg::result_type      walk_result;
   iptrie_pkg::result_type      rsp_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free;
   logic                        rsp_found, found_len_ok;

   logic                        node_we, node_re;
   logic [IW-1:0]               node_waddr, node_raddr;
   logic [NODE_W-1:0]           node_wdata, node_rdata;
   logic                        route_we, route_re;
   logic [IW-1:0]               route_waddr, route_raddr;
   iptrie_pkg::route_entry_type route_wdata, route_rdata;

   assign req_item.cmd      = req_tuser;
   assign req_item.address  = req_tdata[31:0];
   assign req_item.length   = req_tdata[37:32];
   assign req_item.gateway  = req_tdata[69:38];
   assign req_item.iface    = req_tdata[77:70];
   assign req_item.metric   = req_tdata[93:78];

   assign out_free = !rsp_valid_ff || rsp_tready;

   iptrie_walker #(
      .NODE_COUNT (NODE_COUNT)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .out_free    (out_free),
      .result      (walk_result),
      .node_we     (node_we),
      .node_waddr  (node_waddr),
      .node_wdata  (node_wdata),
      .node_re     (node_re),
      .node_raddr  (node_raddr),
      .node_rdata  (node_rdata),
      .route_we    (route_we),
      .route_waddr (route_waddr),
      .route_wdata (route_wdata),
      .route_re    (route_re),
      .route_raddr (route_raddr),
      .route_rdata (route_rdata)
   );

   iptrie_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .re    (node_re),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   iptrie_ram #(
      .WIDTH ($bits(iptrie_pkg::route_entry_type)),
      .DEPTH (NODE_COUNT)
   ) u_route_ram (
      .clock (clock),
      .we    (route_we),
      .waddr (route_waddr),
      .wdata (route_wdata),
      .re    (route_re),
      .raddr (route_raddr),
      .rdata (route_rdata)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (walk_result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (walk_result.valid) begin
         rsp_ff <= walk_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ff.routes, rsp_ff.entry.metric,
                        rsp_ff.entry.iface, rsp_ff.entry.gateway,
                        rsp_ff.entry.length, rsp_ff.entry.prefix};
   assign rsp_tuser  = {rsp_ff.table_full, rsp_ff.found};

   assign rsp_found    = walk_result.valid && walk_result.found;
   assign found_len_ok = (walk_result.entry.length
                          <= iptrie_pkg::len_type'(iptrie_pkg::ADDRESS_BITS))
                         && !walk_result.table_full;

   `IPTRIE_ASSERT_IMPLY(a_result_needs_slot, clock, reset, walk_result.valid, out_free)
   `IPTRIE_ASSERT_IMPLY(a_no_result_when_idle, clock, reset, walk_result.valid, !req_tready)
   `IPTRIE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `IPTRIE_ASSERT_IMPLY(a_found_length_legal, clock, reset, rsp_found, found_len_ok)
endmodule
`default_nettype wire
